FILE: rtl/pkcdt_pkg.sv
// constants, slot word layout and sequencer states for the per-key counter delta table
// no dependencies; imported by per_key_counter_delta_table
`default_nettype none

package pkcdt_pkg;

   // slots per bank; must be a power of two so the home slot is the low id bits
   localparam int TABLE_DEPTH = 8192;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SLOT_COUNT  = 2 * TABLE_DEPTH;
   localparam int ADDR_W      = IDX_W + 1;
   localparam int ID_W        = 22;
   localparam int VAL_W       = 64;

   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(SLOT_COUNT - 1);

   // one memory word: used mark, key and stored counter
   typedef struct packed {
      logic             used;
      logic [ID_W-1:0]  key;
      logic [VAL_W-1:0] value;
   } slot_type;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_FIND_RD  = 7'b0000100,
      ST_FIND_CHK = 7'b0001000,
      ST_DELTA    = 7'b0010000,
      ST_PUT_RD   = 7'b0100000,
      ST_PUT_CHK  = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/per_key_counter_delta_table.sv
// per-key counter delta table: two-bank linear-probing hash with a shared probe sequencer
// depends on pkcdt_pkg
//
// flow: a lookup probes the previous bank, then an insert probes the current bank, each
//   over 1..TABLE_DEPTH slots; every probe is one read of the single slot memory followed
//   by a check state, and the result is registered out of the insert check
// requests: one at a time; busy drops with the result strobe, except after a snapshot-end
//   request, which first clears the used marks of the new current bank
// reset: synchronous; afterwards busy stays high while the used marks of both banks are
//   cleared; the receiver cannot stall, rsp_valid lasts one cycle
`default_nettype none

module per_key_counter_delta_table import pkcdt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [ID_W-1:0]  req_process_id,
   input  wire logic [VAL_W-1:0] req_counter_value,
   input  wire logic             req_snapshot_end,
   output logic                  rsp_valid,
   output logic [ID_W-1:0]       rsp_echo_id,
   output logic [VAL_W-1:0]      rsp_counter_delta,
   output logic                  rsp_delta_valid,
   output logic                  rsp_table_full
);

   // slot memory, both banks
   slot_type slot_mem [SLOT_COUNT];

   state_type         state_ff,  state_in;
   logic              bank_ff,   bank_in;
   logic [IDX_W-1:0]  pos_ff,    pos_in;
   logic [IDX_W-1:0]  probe_ff,  probe_in;
   logic [ADDR_W-1:0] clr_ff,    clr_in;
   logic              clr_all_ff, clr_all_in;
   logic [ID_W-1:0]   id_ff,     id_in;
   logic [VAL_W-1:0]  cur_ff,    cur_in;
   logic              last_ff,   last_in;
   logic [VAL_W-1:0]  prev_ff,   prev_in;
   logic              hit_ff,    hit_in;
   logic [VAL_W-1:0]  delta_ff,  delta_in;
   logic              valid_ff,  valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_full_ff,  rsp_full_in;
   logic [ID_W-1:0]   rsp_id_ff,    rsp_id_in;
   logic [VAL_W-1:0]  rsp_delta_ff, rsp_delta_in;
   logic              rsp_dv_ff,    rsp_dv_in;

   slot_type          rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   slot_type          wr_data;
   logic [VAL_W:0]    diff;
   logic              accept;
   logic              clr_done;
   logic              key_match;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign key_match = rd_data_ff.key == id_ff;
   assign clr_done  = clr_all_ff ? (clr_ff == ADDR_LAST) : (clr_ff[IDX_W-1:0] == IDX_LAST);
   // one wide subtract gives both the borrow (went backwards) and the difference
   assign diff      = {1'b0, cur_ff} - {1'b0, prev_ff};

   // probe read address: lookup goes to the previous bank, insert to the current
   always_comb begin
      rd_addr = {bank_ff, pos_ff};
      if (state_ff == ST_FIND_RD) begin
         rd_addr = {~bank_ff, pos_ff};
      end
   end

   // slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   // probe sequencer
   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      pos_in       = pos_ff;
      probe_in     = probe_ff;
      clr_in       = clr_ff;
      clr_all_in   = clr_all_ff;
      id_in        = id_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      hit_in       = hit_ff;
      delta_in     = delta_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_full_in  = rsp_full_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_delta_in = rsp_delta_ff;
      rsp_dv_in    = rsp_dv_ff;
      wr_en        = 1'b0;
      wr_addr      = {bank_ff, pos_ff};
      wr_data      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep used marks, whole memory after reset, else the new current bank
            wr_en   = 1'b1;
            wr_addr = clr_all_ff ? clr_ff : {bank_ff, clr_ff[IDX_W-1:0]};
            if (clr_done) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               id_in    = req_process_id;
               cur_in   = req_counter_value;
               last_in  = req_snapshot_end;
               pos_in   = req_process_id[IDX_W-1:0];
               probe_in = '0;
               state_in = ST_FIND_RD;
            end
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            // lookup stops at a free slot, a matching key or after a full lap
            priority if (!rd_data_ff.used) begin
               hit_in   = 1'b0;
               state_in = ST_DELTA;
            end else if (key_match) begin
               hit_in   = 1'b1;
               prev_in  = rd_data_ff.value;
               state_in = ST_DELTA;
            end else if (probe_ff == IDX_LAST) begin
               hit_in   = 1'b0;
               state_in = ST_DELTA;
            end else begin
               pos_in   = pos_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
               state_in = ST_FIND_RD;
            end
         end
         ST_DELTA: begin
            valid_in = hit_ff && (prev_ff != '0) && !diff[VAL_W];
            delta_in = (hit_ff && (prev_ff != '0) && !diff[VAL_W]) ? diff[VAL_W-1:0] : '0;
            pos_in   = id_ff[IDX_W-1:0];
            probe_in = '0;
            state_in = ST_PUT_RD;
         end
         ST_PUT_RD: begin
            state_in = ST_PUT_CHK;
         end
         ST_PUT_CHK: begin
            // insert into a free or matching slot, full after a lap with neither
            priority if (!rd_data_ff.used || key_match || probe_ff == IDX_LAST) begin
               if (!rd_data_ff.used || key_match) begin
                  wr_en         = 1'b1;
                  wr_data.used  = 1'b1;
                  wr_data.key   = id_ff;
                  wr_data.value = cur_ff;
                  rsp_full_in   = 1'b0;
               end else begin
                  rsp_full_in   = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff;
               rsp_delta_in = delta_ff;
               rsp_dv_in    = valid_ff;
               if (last_ff) begin
                  bank_in    = ~bank_ff;
                  clr_in     = '0;
                  clr_all_in = 1'b0;
                  state_in   = ST_CLEAR;
               end else begin
                  state_in   = ST_IDLE;
               end
            end else begin
               pos_in   = pos_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
               state_in = ST_PUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         bank_ff      <= 1'b0;
         clr_ff       <= '0;
         clr_all_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         clr_ff       <= clr_in;
         clr_all_ff   <= clr_all_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      probe_ff     <= probe_in;
      id_ff        <= id_in;
      cur_ff       <= cur_in;
      last_ff      <= last_in;
      prev_ff      <= prev_in;
      hit_ff       <= hit_in;
      delta_ff     <= delta_in;
      valid_ff     <= valid_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_dv_ff    <= rsp_dv_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_echo_id       = rsp_id_ff;
   assign rsp_counter_delta = rsp_delta_ff;
   assign rsp_delta_valid   = rsp_dv_ff;
   assign rsp_table_full    = rsp_full_ff;

   // an accepted request always starts with a lookup probe
   a_accept_starts_find: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_FIND_RD)
      else $error("accepted request did not start the lookup");

   // results only come out of the insert check
   a_rsp_from_put: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_PUT_CHK))
      else $error("result strobe without a finished insert");

   // no delta is reported without a valid previous entry
   a_delta_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_dv_ff |-> rsp_delta_ff == '0)
      else $error("nonzero delta on an invalid result");

   // a snapshot end sends the sequencer into the bank clear
   a_snapshot_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> state_ff == ST_CLEAR && !clr_all_ff)
      else $error("snapshot end did not start the bank clear");

   // nothing is accepted while the memory is being cleared
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR && start |=> state_ff != ST_FIND_RD)
      else $error("request taken during the clear pass");

endmodule

`default_nettype wire

FILE: verif/per_key_counter_delta_table_tb.sv
// self-checking testbench for per_key_counter_delta_table: directed, bank-full and random requests
// depends on pkcdt_pkg and per_key_counter_delta_table; keeps its own two-bank hash mirror
`default_nettype none

module per_key_counter_delta_table_tb;
   import pkcdt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 1350;
   localparam int POOL_SIZE    = 32;
   localparam int HOME_COUNT   = 6;
   localparam int STALL_LIMIT  = 16 * TABLE_DEPTH + 1000;
   localparam int TAIL_CYCLES  = TABLE_DEPTH + 64;
   localparam logic [ID_W-1:0]  ID_MAX  = '1;
   localparam logic [VAL_W-1:0] VAL_MAX = '1;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [VAL_W-1:0] value;
      logic             last;
      logic             drain;
      logic             steady;
   } delta_req_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [VAL_W-1:0] delta;
      logic             valid;
      logic             full;
   } delta_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [ID_W-1:0]  req_process_id = '0;
   logic [VAL_W-1:0] req_counter_value = '0;
   logic             req_snapshot_end = 1'b0;
   logic             rsp_valid;
   logic [ID_W-1:0]  rsp_echo_id;
   logic [VAL_W-1:0] rsp_counter_delta;
   logic             rsp_delta_valid;
   logic             rsp_table_full;

   delta_req_type pending_requests[$];
   delta_rsp_type expected_deltas[$];
   int         fail_count = 0;
   int         stall_cycles = 0;
   int         gap_left = 0;
   logic       req_taken = 1'b0;

   // mirror of both banks and the bank pointer
   logic [ID_W-1:0]  shadow_key   [SLOT_COUNT];
   logic [VAL_W-1:0] shadow_value [SLOT_COUNT];
   bit               shadow_used  [SLOT_COUNT];
   bit               shadow_bank = 1'b0;

   // high id bits of the keys that fill one bank completely
   int unsigned fill_hi [TABLE_DEPTH];

   per_key_counter_delta_table DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_process_id    (req_process_id),
      .req_counter_value (req_counter_value),
      .req_snapshot_end  (req_snapshot_end),
      .rsp_valid         (rsp_valid),
      .rsp_echo_id       (rsp_echo_id),
      .rsp_counter_delta (rsp_counter_delta),
      .rsp_delta_valid   (rsp_delta_valid),
      .rsp_table_full    (rsp_table_full)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [ID_W-1:0] make_id(input int unsigned hi, input int unsigned home);
      logic [ID_W-IDX_W-1:0] upper;
      logic [IDX_W-1:0]      lower;
      upper = hi[ID_W-IDX_W-1:0];
      lower = home[IDX_W-1:0];
      return {upper, lower};
   endfunction

   function automatic logic [VAL_W-1:0] random_count();
      return {$urandom(), $urandom()};
   endfunction

   // lookup in the previous bank, insert into the current one, swap on snapshot end
   function automatic delta_rsp_type compute_delta(input logic [ID_W-1:0] id,
                                                   input logic [VAL_W-1:0] value,
                                                   input logic last);
      delta_rsp_type    r;
      int unsigned      cur_base, prev_base, pos, n;
      logic             stop, found, placed;
      logic [VAL_W-1:0] prev_value;
      cur_base   = shadow_bank ? TABLE_DEPTH : 0;
      prev_base  = shadow_bank ? 0 : TABLE_DEPTH;
      stop       = 1'b0;
      found      = 1'b0;
      placed     = 1'b0;
      prev_value = '0;

      // probe stops at the first free slot, a matching key or after a whole bank
      pos = id % TABLE_DEPTH;
      for (n = 0; n < TABLE_DEPTH && !stop; n++) begin
         if (!shadow_used[prev_base + pos]) begin
            stop = 1'b1;
         end else if (shadow_key[prev_base + pos] == id) begin
            stop       = 1'b1;
            found      = 1'b1;
            prev_value = shadow_value[prev_base + pos];
         end else begin
            pos = (pos + 1) % TABLE_DEPTH;
         end
      end

      r.id    = id;
      r.valid = found && (prev_value != '0) && (value >= prev_value);
      r.delta = r.valid ? value - prev_value : '0;

      // insert or overwrite in the current bank
      pos = id % TABLE_DEPTH;
      for (n = 0; n < TABLE_DEPTH && !placed; n++) begin
         if (!shadow_used[cur_base + pos] || shadow_key[cur_base + pos] == id) begin
            shadow_key[cur_base + pos]   = id;
            shadow_value[cur_base + pos] = value;
            shadow_used[cur_base + pos]  = 1'b1;
            placed = 1'b1;
         end else begin
            pos = (pos + 1) % TABLE_DEPTH;
         end
      end
      r.full = !placed;

      // old previous bank becomes the empty current bank
      if (last) begin
         shadow_bank = ~shadow_bank;
         for (n = 0; n < TABLE_DEPTH; n++) shadow_used[prev_base + n] = 1'b0;
      end
      return r;
   endfunction

   task automatic queue_request(input logic [ID_W-1:0] id, input logic [VAL_W-1:0] value,
                                input logic last, input logic drain = 1'b0,
                                input logic steady = 1'b0);
      delta_req_type rq;
      rq.id     = id;
      rq.value  = value;
      rq.last   = last;
      rq.drain  = drain;
      rq.steady = steady;
      pending_requests.push_back(rq);
   endtask

   task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // request driver: next request goes out once the previous one is taken
   always @(negedge clock) begin : driver
      delta_req_type next_req;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            start <= 1'b0;
         end else if (pending_requests[0].drain && expected_deltas.size() != 0) begin
            start <= 1'b0;
         end else if (!pending_requests[0].steady && $urandom_range(99) < 19) begin
            gap_left <= $urandom_range(0, 9);
            start    <= 1'b0;
         end else begin
            next_req          = pending_requests.pop_front();
            req_process_id    <= next_req.id;
            req_counter_value <= next_req.value;
            req_snapshot_end  <= next_req.last;
            start             <= 1'b1;
         end
      end
   end

   // monitor: check results against the oldest expectation, predict accepted requests
   always @(posedge clock) begin : monitor
      delta_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_deltas.size() == 0) begin
               $display("%0t: result with nothing expected, actual id %h delta %h",
                        $time, rsp_echo_id, rsp_counter_delta);
               fail_count++;
            end else begin
               want = expected_deltas.pop_front();
               check_field("echo_id", VAL_W'(want.id), VAL_W'(rsp_echo_id));
               check_field("counter_delta", want.delta, rsp_counter_delta);
               check_field("delta_valid", VAL_W'(want.valid), VAL_W'(rsp_delta_valid));
               check_field("table_full", VAL_W'(want.full), VAL_W'(rsp_table_full));
            end
         end
         req_taken <= start && !busy;
         if (start && !busy)
            expected_deltas.push_back(compute_delta(req_process_id, req_counter_value,
                                                    req_snapshot_end));
      end
   end

   // watchdog on cycles with no request or result accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [ID_W-1:0]  pool_id  [POOL_SIZE];
      logic [VAL_W-1:0] pool_val [POOL_SIZE];
      int unsigned      homes    [HOME_COUNT];
      logic [ID_W-1:0]  id;
      logic [VAL_W-1:0] value;
      int unsigned      a, b, c, d, e, p, roll, len, k, snap, random_items;

      // directed: extremes, collisions with wrap, overwrite, zero and backwards counters
      queue_request('0, '0, 1'b0);
      queue_request(ID_MAX, VAL_MAX, 1'b0);
      queue_request(make_id(1, IDX_LAST), 64'd5, 1'b0);
      queue_request(make_id(2, 0), 64'd100, 1'b0);
      queue_request(make_id(3, 5), 64'd7, 1'b0);
      queue_request(make_id(3, 5), 64'd9, 1'b0);
      queue_request(make_id(4, 6), 64'h8000_0000_0000_0000, 1'b1);
      queue_request('0, 64'd10, 1'b0);
      queue_request(ID_MAX, VAL_MAX, 1'b0);
      queue_request(make_id(1, IDX_LAST), 64'd4, 1'b0);
      queue_request(make_id(2, 0), VAL_MAX, 1'b0);
      queue_request(make_id(3, 5), 64'd20, 1'b0);
      queue_request(make_id(5, 0), 64'd1, 1'b0);
      queue_request(make_id(4, 6), 64'h8000_0000_0000_0001, 1'b0);
      queue_request(22'h15_5555, 64'h5555_5555_5555_5555, 1'b1);
      queue_request(22'h2A_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_request(ID_MAX, '0, 1'b0);
      queue_request(make_id(2, 0), 64'd2, 1'b0);
      queue_request(make_id(0, 1), 64'd1, 1'b1);

      // fill one bank to the last slot, then overflow it
      for (k = 0; k < TABLE_DEPTH; k++) begin
         fill_hi[k] = $urandom();
         queue_request(make_id(fill_hi[k], k), random_count() | 64'd1, 1'b0, k == 0);
      end
      a = $urandom_range(0, TABLE_DEPTH - 1);
      b = $urandom_range(0, TABLE_DEPTH - 1);
      c = $urandom_range(0, TABLE_DEPTH - 1);
      d = $urandom_range(0, TABLE_DEPTH - 1);
      e = $urandom_range(0, TABLE_DEPTH - 1);
      queue_request(make_id(fill_hi[a] ^ 1, a), random_count(), 1'b0);
      queue_request(make_id(fill_hi[b], b), VAL_MAX, 1'b0);
      queue_request(make_id(fill_hi[c] ^ 2, c), random_count(), 1'b1);
      // lookups against the full previous bank, one of them a miss over the whole bank
      queue_request(make_id(fill_hi[d], d), VAL_MAX, 1'b0);
      queue_request(make_id(fill_hi[e] ^ 1, e), 64'd5, 1'b0);
      queue_request(make_id(fill_hi[b], b), '0, 1'b1);

      // random snapshots over a pool of colliding keys, with some noise keys
      homes[0] = TABLE_DEPTH - 1;
      homes[1] = 0;
      for (k = 2; k < HOME_COUNT; k++) homes[k] = $urandom_range(0, TABLE_DEPTH - 1);
      for (k = 0; k < POOL_SIZE; k++) begin
         pool_id[k]  = make_id($urandom(), homes[$urandom_range(0, HOME_COUNT - 1)]);
         pool_val[k] = VAL_W'($urandom_range(1, 1000));
      end
      snap = 0;
      random_items = 0;
      while (random_items < ITEM_TARGET) begin
         len = $urandom_range(8, 48);
         for (k = 0; k < len; k++) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
               id    = ID_W'($urandom());
               value = random_count();
            end else begin
               p  = $urandom_range(0, POOL_SIZE - 1);
               id = pool_id[p];
               if (roll < 70)
                  value = pool_val[p] + $urandom_range(0, 5000);
               else if (roll < 80)
                  value = pool_val[p] + $urandom();
               else if (roll < 88)
                  value = pool_val[p] - $urandom_range(1, 100);
               else if (roll < 93)
                  value = '0;
               else
                  value = random_count();
               pool_val[p] = value;
            end
            queue_request(id, value, k == len - 1, snap == 0 && k == 0,
                          snap >= 8 && snap < 16);
            random_items++;
         end
         // keys leave and join between snapshots
         p = $urandom_range(0, POOL_SIZE - 1);
         pool_id[p]  = make_id($urandom(), homes[$urandom_range(0, HOME_COUNT - 1)]);
         pool_val[p] = VAL_W'($urandom_range(1, 1000));
         snap++;
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // wait for every request to go out and every result to come back
      while (pending_requests.size() != 0 || start || expected_deltas.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

FILE: per_key_counter_delta_table.f
rtl/pkcdt_pkg.sv
rtl/per_key_counter_delta_table.sv
verif/per_key_counter_delta_table_tb.sv
